// File: hdl/bsl_pkg.sv
`timescale 1ns / 1ps

package bsl_pkg;

  // Fixed field widths of the request and result items.
  localparam int REQ_W   = 3;
  localparam int POS_W   = 7;
  localparam int VALUE_W = 32;
  localparam int STAT_W  = 2;
  localparam int FIDX_W  = 7;
  localparam int COUNT_W = 7;

  // Request codes.
  localparam logic [REQ_W-1:0] REQ_PUSH_BACK  = 3'd0;
  localparam logic [REQ_W-1:0] REQ_PUSH_FRONT = 3'd1;
  localparam logic [REQ_W-1:0] REQ_POP_BACK   = 3'd2;
  localparam logic [REQ_W-1:0] REQ_POP_FRONT  = 3'd3;
  localparam logic [REQ_W-1:0] REQ_INSERT     = 3'd4;
  localparam logic [REQ_W-1:0] REQ_ERASE      = 3'd5;
  localparam logic [REQ_W-1:0] REQ_FIND       = 3'd6;

  // Status codes.
  localparam logic [STAT_W-1:0] STAT_OK     = 2'd0;
  localparam logic [STAT_W-1:0] STAT_FULL   = 2'd1;
  localparam logic [STAT_W-1:0] STAT_EMPTY  = 2'd2;
  localparam logic [STAT_W-1:0] STAT_BADPOS = 2'd3;

  // Index reported when a find misses or the request is not a find.
  localparam logic [FIDX_W-1:0] NOT_FOUND = 7'h7F;

  // Broadcast control from the sequencer to every cell.
  typedef struct packed {
    logic open_gap;   // cells above the slot take their lower neighbor
    logic close_gap;  // cells at and above the slot take their upper neighbor
    logic tok_start;  // launch the search token at cell zero
    logic tok_adv;    // move the search token up one cell
  } bsl_ctrl_t;

endpackage

// File: hdl/bounded_sequence_list.sv
`timescale 1ns / 1ps
// Push, pop, insert, erase and find on an empty list register their result item, which
// appears in the cycle after the request is accepted. A find walks a token up the cells,
// one cell a cycle, giving its result on a hit or at the last item. Throughput: one item
// a cycle but for find while out_ready is high; a find holds off the next item until done.
// Reset (rst_n, synchronous, active low) empties the list and drops any pending result.
module bounded_sequence_list #(
  parameter int DEPTH      = 64,
  parameter int DATA_WIDTH = 32
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [bsl_pkg::REQ_W-1:0]           in_req_type,
  input  logic [bsl_pkg::POS_W-1:0]           in_position,
  input  logic signed [bsl_pkg::VALUE_W-1:0]  in_value,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [bsl_pkg::STAT_W-1:0]          out_status,
  output logic signed [bsl_pkg::FIDX_W-1:0]   out_found_index,
  output logic [bsl_pkg::COUNT_W-1:0]         out_count
);
  import bsl_pkg::*;

  // CW holds a count from zero up to DEPTH, IW indexes one cell, and CMPW is wide
  // enough to compare a request position against the count without losing bits.
  localparam int CW   = $clog2(DEPTH + 1);
  localparam int IW   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CMPW = (CW > POS_W) ? CW : POS_W;

  // Sequencer states: idle takes requests, scan walks the find token.
  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_SCAN = 1'b1;

  logic                  state_r;
  logic                  state_nxt;
  logic [CW-1:0]         count_r;
  logic [CW-1:0]         count_nxt;
  logic [IW-1:0]         scan_idx_r;
  logic [IW-1:0]         scan_idx_nxt;
  logic [DATA_WIDTH-1:0] key_r;
  logic [DATA_WIDTH-1:0] key_nxt;

  // Output register; it parts the request side from the result side.
  logic                  out_valid_r;
  logic [STAT_W-1:0]     out_status_r;
  logic [FIDX_W-1:0]     out_found_r;
  logic [COUNT_W-1:0]    out_count_r;

  logic                  res_load;
  logic [STAT_W-1:0]     res_status;
  logic [FIDX_W-1:0]     res_found;

  bsl_ctrl_t             ctrl;
  logic [IW-1:0]         at;
  logic [DATA_WIDTH-1:0] wdata;

  logic                  in_fire;
  logic                  out_free;
  logic                  is_full;
  logic                  is_empty;
  logic [CMPW-1:0]       cnt_ext;
  logic [CMPW-1:0]       pos_ext;

  logic [DATA_WIDTH-1:0] cell_data [DEPTH];
  logic [DEPTH-1:0]      tok;
  logic [DEPTH-1:0]      hit;

  assign out_free = !out_valid_r || out_ready;
  // A new request is taken only when idle and the result slot is free (or draining now).
  assign in_ready = (state_r == ST_IDLE) && out_free;
  assign in_fire  = in_valid && in_ready;

  assign is_full  = (count_r == CW'(DEPTH));
  assign is_empty = (count_r == '0);
  assign cnt_ext  = CMPW'(count_r);
  assign pos_ext  = CMPW'(in_position);

  // Only the low DATA_WIDTH bits of a value are stored and compared.
  assign wdata    = DATA_WIDTH'($unsigned(in_value));

  always_comb begin
    state_nxt    = state_r;
    count_nxt    = count_r;
    scan_idx_nxt = scan_idx_r;
    key_nxt      = key_r;
    ctrl         = '0;
    at           = '0;
    res_load     = 1'b0;
    res_status   = STAT_OK;
    res_found    = NOT_FOUND;

    case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          res_load = 1'b1;
          case (in_req_type) inside
            REQ_PUSH_BACK, REQ_PUSH_FRONT: begin
              if (is_full) begin
                res_status = STAT_FULL;
              end else begin
                ctrl.open_gap = 1'b1;
                at            = (in_req_type == REQ_PUSH_BACK) ? IW'(count_r) : '0;
                count_nxt     = count_r + CW'(1);
              end
            end
            REQ_POP_BACK, REQ_POP_FRONT: begin
              if (is_empty) begin
                res_status = STAT_EMPTY;
              end else begin
                // Popping the back only drops the count; the front needs a shift down.
                ctrl.close_gap = (in_req_type == REQ_POP_FRONT);
                count_nxt      = count_r - CW'(1);
              end
            end
            REQ_INSERT: begin
              // A bad position is reported ahead of a full list.
              if (pos_ext > cnt_ext) begin
                res_status = STAT_BADPOS;
              end else if (is_full) begin
                res_status = STAT_FULL;
              end else begin
                ctrl.open_gap = 1'b1;
                at            = IW'(pos_ext);
                count_nxt     = count_r + CW'(1);
              end
            end
            REQ_ERASE: begin
              if (is_empty) begin
                res_status = STAT_EMPTY;
              end else if (pos_ext >= cnt_ext) begin
                res_status = STAT_BADPOS;
              end else begin
                ctrl.close_gap = 1'b1;
                at             = IW'(pos_ext);
                count_nxt      = count_r - CW'(1);
              end
            end
            REQ_FIND: begin
              // An empty list misses at once; otherwise start the token at cell zero.
              if (!is_empty) begin
                res_load       = 1'b0;
                ctrl.tok_start = 1'b1;
                key_nxt        = wdata;
                scan_idx_nxt   = '0;
                state_nxt      = ST_SCAN;
              end
            end
            default: begin
            end
          endcase
        end
      end
      ST_SCAN: begin
        // The cell holding the token compares against the key. The result slot is
        // known to be free here, since it was free when the find was accepted.
        if (|hit) begin
          res_load  = 1'b1;
          res_found = FIDX_W'(scan_idx_r);
          state_nxt = ST_IDLE;
        end else if (CW'(scan_idx_r) == (count_r - CW'(1))) begin
          res_load  = 1'b1;
          state_nxt = ST_IDLE;
        end else begin
          ctrl.tok_adv = 1'b1;
          scan_idx_nxt = scan_idx_r + IW'(1);
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      if (res_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    scan_idx_r <= scan_idx_nxt;
    key_r      <= key_nxt;
    if (res_load) begin
      out_status_r <= res_status;
      out_found_r  <= res_found;
      out_count_r  <= COUNT_W'(count_nxt);
    end
  end

  assign out_valid       = out_valid_r;
  assign out_status      = out_status_r;
  assign out_found_index = out_found_r;
  assign out_count       = out_count_r;

  // The row of cells. Each cell sees its lower and upper neighbor for the shifts and
  // passes the search token to the cell above it.
  for (genvar gi = 0; gi < DEPTH; gi++) begin : g_cell
    logic [DATA_WIDTH-1:0] left_d;
    logic [DATA_WIDTH-1:0] right_d;
    logic                  tok_lo;

    if (gi == 0) begin : g_first
      assign left_d = '0;
      assign tok_lo = 1'b0;
    end else begin : g_mid
      assign left_d = cell_data[gi-1];
      assign tok_lo = tok[gi-1];
    end

    if (gi == DEPTH - 1) begin : g_last
      assign right_d = cell_data[gi];
    end else begin : g_inner
      assign right_d = cell_data[gi+1];
    end

    bsl_cell #(
      .DATA_WIDTH (DATA_WIDTH),
      .IW         (IW),
      .IDX        (gi)
    ) u_cell (
      .clk        (clk),
      .rst_n      (rst_n),
      .ctrl       (ctrl),
      .at         (at),
      .wdata      (wdata),
      .left_data  (left_d),
      .right_data (right_d),
      .key        (key_r),
      .tok_in     (tok_lo),
      .data_out   (cell_data[gi]),
      .tok_out    (tok[gi]),
      .hit        (hit[gi])
    );
  end

  // The count never exceeds the capacity.
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(DEPTH))
    else $error("element count beyond capacity");

  // While scanning exactly one cell holds the token, and it is the one being indexed.
  a_scan_token: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SCAN) |-> ($onehot(tok) && tok[scan_idx_r]))
    else $error("search token lost or out of step");

  // No token is left in the row once the sequencer is idle.
  a_idle_token: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_IDLE) |-> (tok == '0))
    else $error("stray search token while idle");

  // A push into a list with room grows it by exactly one.
  a_push_grows: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && ((in_req_type == REQ_PUSH_BACK) || (in_req_type == REQ_PUSH_FRONT))
     && !is_full) |=> (count_r == $past(count_r) + CW'(1)))
    else $error("push did not grow the list");

  // A scan only runs while the list holds at least one item.
  a_scan_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SCAN) |-> !is_empty)
    else $error("scan running on an empty list");

endmodule

// File: hdl/bsl_cell.sv
`timescale 1ns / 1ps

module bsl_cell #(
  parameter int DATA_WIDTH = 32,
  parameter int IW         = 6,
  parameter int IDX        = 0
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  bsl_pkg::bsl_ctrl_t    ctrl,
  input  logic [IW-1:0]         at,
  input  logic [DATA_WIDTH-1:0] wdata,
  input  logic [DATA_WIDTH-1:0] left_data,
  input  logic [DATA_WIDTH-1:0] right_data,
  input  logic [DATA_WIDTH-1:0] key,
  input  logic                  tok_in,
  output logic [DATA_WIDTH-1:0] data_out,
  output logic                  tok_out,
  output logic                  hit
);
  import bsl_pkg::*;

  localparam logic [IW-1:0] MY_IDX = IW'(IDX);

  logic [DATA_WIDTH-1:0] data_r;
  logic [DATA_WIDTH-1:0] data_nxt;
  logic                  tok_r;
  logic                  tok_nxt;

  always_comb begin
    data_nxt = data_r;
    if (ctrl.open_gap) begin
      if (MY_IDX > at) begin
        data_nxt = left_data;
      end else if (MY_IDX == at) begin
        data_nxt = wdata;
      end
    end else if (ctrl.close_gap && (MY_IDX >= at)) begin
      data_nxt = right_data;
    end
  end

  always_comb begin
    if (ctrl.tok_start) begin
      tok_nxt = (IDX == 0);
    end else if (ctrl.tok_adv) begin
      tok_nxt = tok_in;
    end else begin
      tok_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tok_r <= 1'b0;
    end else begin
      tok_r <= tok_nxt;
    end
  end

  assign data_out = data_r;
  assign tok_out  = tok_r;
  assign hit      = tok_r && (data_r == key);

endmodule
